### design/chm_pkg.sv
// chm_pkg: types, constants and helper functions of the chained hash map
// no dependencies; imported by chm_ram and the top level
`default_nettype none

package chm_pkg;

  // field widths of one item
  localparam int unsigned KeyW   = 31;
  localparam int unsigned ValueW = 31;

  // default table sizes
  localparam int unsigned DefBuckets = 1024;
  localparam int unsigned DefNodes   = 512;

  // multiplicative hash constant
  localparam logic [31:0] HashMult = 32'd1103515249;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_HASH   = 8'b0000_0100,
    ST_BREAD  = 8'b0000_1000,
    ST_BWAIT  = 8'b0001_0000,
    ST_NWAIT  = 8'b0010_0000,
    ST_INSERT = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } chm_state_e;

  // log2 of the bucket count rounded up to a power of two, at least 1
  function automatic int unsigned table_log2(input int unsigned buckets);
    int unsigned lg;
    lg = 1;
    while (((32'd1 << lg) < buckets) && (lg < 30)) begin
      lg = lg + 1;
    end
    return lg;
  endfunction

  // address width for a memory of the given depth, at least 1
  function automatic int unsigned addr_width(input int unsigned depth);
    return (depth <= 2) ? 1 : $clog2(depth);
  endfunction

endpackage

`default_nettype wire

### design/chained_integer_hash_map_top.sv
// chained_integer_hash_map_top: integer key to value map, chained hash table
// Each item steps through HASH, BREAD and BWAIT, one NWAIT per chain node visited,
// an INSERT state for an insert of a new key while the node pool has room, and
// DONE, where the result waits for a free output register. Input ready only when
// the sequencer is idle, so a new item is taken only after the last result is registered.
// The chain walk through the node ram port sets the per-item cycle count.
// Reset: asynchronous, active low; then a clearing pass writes an empty head to
// each of the 2^ceil(log2 BUCKETS) buckets before the first item is taken.
// Depends on chm_pkg and chm_ram.
`default_nettype none

module chained_integer_hash_map_top
  import chm_pkg::*;
#(
  parameter int unsigned Buckets = DefBuckets,
  parameter int unsigned Nodes   = DefNodes
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input items
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,  // [30:0] key, [61:31] value, [63:62] zero
  input  wire         s_axis_tuser,  // [0] action: 0 lookup, 1 insert
  // result items
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata   // [0] hit, [31:1] found_value, [32] full_res, rest zero
);

  localparam int unsigned Lg     = table_log2(Buckets);
  localparam int unsigned NumBkt = 1 << Lg;
  localparam int unsigned BktLsb = 30 - Lg;
  localparam int unsigned NodeW  = addr_width(Nodes);
  localparam int unsigned CntW   = $clog2(Nodes + 1);
  localparam int unsigned BktW   = NodeW + 1;
  localparam int unsigned NodeDW = KeyW + ValueW + NodeW + 1;

  chm_state_e state_q, state_d;

  logic                action_q;
  logic [KeyW-1:0]     key_q;
  logic [ValueW-1:0]   value_q;
  logic [31:0]         prod_q;
  logic [Lg-1:0]       bkt_q;
  logic [Lg-1:0]       clr_q;
  logic [NodeW-1:0]    head_q;
  logic                have_q;
  logic [CntW-1:0]     count_q;
  logic                hit_q, full_q;
  logic [ValueW-1:0]   found_q;
  logic                m_valid_q;
  logic [39:0]         m_data_q;

  // bucket ram signals
  logic              bkt_we, bkt_re;
  logic [Lg-1:0]     bkt_waddr, bkt_raddr;
  logic [BktW-1:0]   bkt_wdata, bkt_rdata;
  logic              rd_have;
  logic [NodeW-1:0]  rd_head;

  // node ram signals
  logic              node_we, node_re;
  logic [NodeW-1:0]  node_waddr, node_raddr;
  logic [NodeDW-1:0] node_wdata, node_rdata;
  logic [KeyW-1:0]   rd_key;
  logic [ValueW-1:0] rd_value;
  logic [NodeW-1:0]  rd_link;
  logic              rd_link_valid;

  logic in_acc, pool_full, key_match, out_free;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign pool_full     = (count_q == CntW'(Nodes));
  assign out_free      = !m_valid_q || m_axis_tready;

  assign {rd_have, rd_head} = bkt_rdata;
  assign {rd_link_valid, rd_link, rd_value, rd_key} = node_rdata;
  assign key_match = (rd_key == key_q);

  // bucket ram: clearing pass writes empty heads, insert writes the new head
  assign bkt_we    = (state_q == ST_CLEAR) || (state_q == ST_INSERT);
  assign bkt_waddr = (state_q == ST_CLEAR) ? clr_q : bkt_q;
  assign bkt_wdata = (state_q == ST_CLEAR) ? '0 : {1'b1, count_q[NodeW-1:0]};
  assign bkt_re    = (state_q == ST_BREAD);
  assign bkt_raddr = prod_q[BktLsb +: Lg];

  // node ram: insert writes the new node; reads fetch the chain head, then follow links
  assign node_we    = (state_q == ST_INSERT);
  assign node_waddr = count_q[NodeW-1:0];
  assign node_wdata = {have_q, head_q, value_q, key_q};
  assign node_re    = (state_q == ST_BWAIT) || (state_q == ST_NWAIT);
  assign node_raddr = (state_q == ST_BWAIT) ? rd_head : rd_link;

  chm_ram #(
    .Width (BktW),
    .Depth (NumBkt)
  ) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (bkt_wdata),
    .re_i    (bkt_re),
    .raddr_i (bkt_raddr),
    .rdata_o (bkt_rdata)
  );

  chm_ram #(
    .Width (NodeDW),
    .Depth (Nodes)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:   if (in_acc) state_d = ST_HASH;
      ST_HASH:   state_d = ST_BREAD;
      ST_BREAD:  state_d = ST_BWAIT;
      ST_BWAIT: begin
        if (rd_have) begin
          state_d = ST_NWAIT;
        end else if (action_q && !pool_full) begin
          state_d = ST_INSERT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_NWAIT: begin
        if (key_match) begin
          state_d = ST_DONE;
        end else if (rd_link_valid) begin
          state_d = ST_NWAIT;
        end else if (action_q && !pool_full) begin
          state_d = ST_INSERT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_INSERT: state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == ST_INSERT) begin
        count_q <= count_q + 1'b1;
      end
      if ((state_q == ST_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // item and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= s_axis_tuser;
      key_q    <= s_axis_tdata[KeyW-1:0];
      value_q  <= s_axis_tdata[KeyW +: ValueW];
      hit_q    <= 1'b0;
      full_q   <= 1'b0;
      found_q  <= '0;
    end
    // multiplier, low 32 bits of the product
    if (state_q == ST_HASH) begin
      prod_q <= 32'({1'b0, key_q} * HashMult);
    end
    if (state_q == ST_BREAD) begin
      bkt_q <= bkt_raddr;
    end
    if (state_q == ST_BWAIT) begin
      have_q <= rd_have;
      head_q <= rd_head;
      if (!rd_have && action_q && pool_full) begin
        full_q <= 1'b1;
      end
    end
    if (state_q == ST_NWAIT) begin
      if (key_match) begin
        hit_q   <= 1'b1;
        found_q <= rd_value;
      end else if (!rd_link_valid && action_q && pool_full) begin
        full_q <= 1'b1;
      end
    end
    // result register
    if ((state_q == ST_DONE) && out_free) begin
      m_data_q <= {7'd0, full_q, found_q, hit_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

### design/chm_ram.sv
// chm_ram: generic simple dual-port ram, one write and one registered read port
// uses chm_pkg for the address width helper
`default_nettype none

module chm_ram
  import chm_pkg::*;
#(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                           clk_i,
  input  wire                           we_i,
  input  wire  [addr_width(Depth)-1:0]  waddr_i,
  input  wire  [Width-1:0]              wdata_i,
  input  wire                           re_i,
  input  wire  [addr_width(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, data held when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
